// File: sv/sglm_pkg.sv
// ----------------------------------------------------------------------------
// sglm_pkg
// Shared widths, constants and control types of the sequence gap loss monitor.
// ----------------------------------------------------------------------------
package sglm_pkg;

  // Default parameter values
  localparam int unsigned CHANNELS_DEF   = 16;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // Payload widths
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned PAIR_W = 2 * ID_W;
  localparam int unsigned TOT_W  = 32;
  localparam int unsigned LOSS_W = 15;

  // Loss scale is 25600 = 25 * 2^10 (100 percent in 1/256 steps)
  localparam int unsigned SCALE_SHIFT = 10;
  localparam logic [LOSS_W-1:0] LOSS_SCALE = 15'd25600;

  // Ratio divider: quotient stays below 2^15, one bit per step
  localparam int unsigned DIV_STEPS = LOSS_W;
  localparam int unsigned DEN_SHIFT = DIV_STEPS - 1;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Report every 32nd frame of a channel
  localparam int unsigned REPORT_W = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;     // clear one seen entry
    logic load;      // capture an accepted request
    logic read;      // read pair memories and channel counters
    logic update;    // compute gap, bump counters, write back
    logic mul1;      // numerator partial sum, load denominator
    logic mul2;      // finish numerator
    logic div_step;  // one restoring division step
    logic smooth;    // average, write back, load output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;  // clearing pass at its final entry
    logic out_free;  // output register can take a result
  } dp_status_t;

endpackage

// File: sv/sglm_intf.sv
// ----------------------------------------------------------------------------
// sglm_in_if / sglm_out_if
// Valid/ready channels for frame requests and loss results.
// ----------------------------------------------------------------------------
interface sglm_in_if import sglm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [ID_W-1:0]   sys_id;
  logic [ID_W-1:0]   comp_id;
  logic [SEQ_W-1:0]  seq;

  modport source (output valid, channel, sys_id, comp_id, seq, input ready);
  modport sink   (input valid, channel, sys_id, comp_id, seq, output ready);
endinterface

interface sglm_out_if import sglm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  lost_now;
  logic [TOT_W-1:0]  received_total;
  logic [TOT_W-1:0]  lost_total;
  logic [LOSS_W-1:0] loss_percent;
  logic              report;

  modport source (output valid, lost_now, received_total, lost_total, loss_percent,
                  report, input ready);
  modport sink   (input valid, lost_now, received_total, lost_total, loss_percent,
                  report, output ready);
endinterface

// File: sv/sequence_gap_loss_monitor.sv
// ----------------------------------------------------------------------------
// sequence_gap_loss_monitor
// Per-sender sequence gap detection with per-channel loss statistics.
// ----------------------------------------------------------------------------
// Usage:
//   frame_i takes one request per completed frame: channel, sender system and
//   component identifiers and the 8-bit sequence number. result_o returns one
//   result per request: frames missed from that sender pair, the channel's
//   saturating received and lost totals, the smoothed loss in 1/256 percent
//   and a report flag on every 32nd frame of the channel.
//   A request is taken only in idle, so the next one waits until the previous
//   result is loaded into the output register. The loss ratio comes from a
//   restoring divider, one quotient bit per cycle; before it come the pair
//   memory read, counter updates and scaling; after it the smoothing step.
//   After reset the sender seen table is cleared one entry a cycle, with
//   frame_i.ready low throughout. Channel counters clear at once.
//   A result waits in the output register while result_o is stalled; the next
//   request is still accepted and processed, and stops at its last step until
//   the output register is free.
// ----------------------------------------------------------------------------
module sequence_gap_loss_monitor import sglm_pkg::*; #(
  parameter int unsigned CHANNELS   = CHANNELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  sglm_in_if.sink     frame_i,
  sglm_out_if.source  result_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  sglm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .status_i   (status),
    .in_ready_o (frame_i.ready),
    .cmd_o      (cmd)
  );

  // Datapath
  sglm_dp #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .channel_i        (frame_i.channel),
    .sys_id_i         (frame_i.sys_id),
    .comp_id_i        (frame_i.comp_id),
    .seq_i            (frame_i.seq),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .lost_now_o       (result_o.lost_now),
    .received_total_o (result_o.received_total),
    .lost_total_o     (result_o.lost_total),
    .loss_percent_o   (result_o.loss_percent),
    .report_o         (result_o.report)
  );

endmodule

// File: sv/sglm_ctrl.sv
// ----------------------------------------------------------------------------
// sglm_ctrl
// Sequencer: clearing pass, request acceptance and per-frame command steps.
// ----------------------------------------------------------------------------
module sglm_ctrl import sglm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_SMOOTH
  } state_e;

  state_e            state_q, state_d;
  logic              ready_q;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  // Decode next state and step count
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && ready_q) state_d = S_READ;
      end
      S_READ:   state_d = S_UPDATE;
      S_UPDATE: state_d = S_MUL1;
      S_MUL1:   state_d = S_MUL2;
      S_MUL2: begin
        state_d = S_DIV;
        cnt_d   = STEP_W'(DIV_STEPS - 1);
      end
      S_DIV: begin
        if (cnt_q == '0) state_d = S_SMOOTH;
        else cnt_d = cnt_q - 1'b1;
      end
      S_SMOOTH: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ready_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
      cnt_q   <= cnt_d;
    end
  end

  // Issue datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.clear    = (state_q == S_CLEAR);
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i && ready_q;
    cmd_o.read     = (state_q == S_READ);
    cmd_o.update   = (state_q == S_UPDATE);
    cmd_o.mul1     = (state_q == S_MUL1);
    cmd_o.mul2     = (state_q == S_MUL2);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.smooth   = (state_q == S_SMOOTH) && status_i.out_free;
  end

  assign in_ready_o = ready_q;

  // Checks
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && ready_q) |=> (state_q == S_READ))
    else $error("accepted request did not start a read");

  a_no_ready_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !ready_q)
    else $error("ready raised during clearing pass");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (state_q == S_IDLE))
    else $error("ready raised outside idle");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < STEP_W'(DIV_STEPS)))
    else $error("division step count out of range");

endmodule

// File: sv/sglm_dp.sv
// ----------------------------------------------------------------------------
// sglm_dp
// Datapath: pair memories, channel counters, ratio divider, output register.
// ----------------------------------------------------------------------------
module sglm_dp import sglm_pkg::*; #(
  parameter int unsigned CHANNELS   = CHANNELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  input  logic [CHAN_W-1:0] channel_i,
  input  logic [ID_W-1:0]   sys_id_i,
  input  logic [ID_W-1:0]   comp_id_i,
  input  logic [SEQ_W-1:0]  seq_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SEQ_W-1:0]  lost_now_o,
  output logic [TOT_W-1:0]  received_total_o,
  output logic [TOT_W-1:0]  lost_total_o,
  output logic [LOSS_W-1:0] loss_percent_o,
  output logic              report_o
);

  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PAIRS = 1 << PAIR_W;
  localparam int unsigned NUM_W = COUNT_BITS + LOSS_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Pair memories
  logic             seen_mem [PAIRS];
  logic [SEQ_W-1:0] last_mem [PAIRS];

  // Channel state
  logic [COUNT_BITS-1:0] recv_q   [CHANNELS];
  logic [COUNT_BITS-1:0] lost_q   [CHANNELS];
  logic [LOSS_W-1:0]     smooth_q [CHANNELS];

  // Working registers
  logic [CH_W-1:0]       ch_q;
  logic [CH_W-1:0]       ch_mod;
  logic [PAIR_W-1:0]     pair_q;
  logic [PAIR_W-1:0]     clr_q;
  logic [SEQ_W-1:0]      seq_q;
  logic                  seen_rd_q;
  logic [SEQ_W-1:0]      last_rd_q;
  logic [COUNT_BITS-1:0] rc_q, lc_q;
  logic [LOSS_W-1:0]     sm_old_q;
  logic [SEQ_W-1:0]      gap_q;
  logic [NUM_W-1:0]      num_q, den_q;
  logic [LOSS_W-1:0]     quo_q;
  logic                  out_valid_q;

  // Combinational helpers
  logic [SEQ_W-1:0]      gap;
  logic [COUNT_BITS-1:0] rc_new, lc_new;
  logic [COUNT_BITS:0]   lsum, dsum;
  logic [NUM_W-1:0]      ntmp;
  logic [LOSS_W:0]       sm_sum;
  logic                  num_ge;

  // Fold the channel into range by a small constant table
  always_comb begin
    ch_mod = '0;
    for (int i = 0; i < (1 << CHAN_W); i++) begin
      if (channel_i == CHAN_W'(i)) ch_mod = CH_W'(i % CHANNELS);
    end
  end

  // Capture an accepted request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q   <= ch_mod;
      pair_q <= {sys_id_i, comp_id_i};
      seq_q  <= seq_i;
    end
  end

  // Advance the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign status_o.clr_last = (clr_q == '1);

  // Seen flag memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      seen_mem[clr_q] <= 1'b0;
    end else if (cmd_i.update) begin
      seen_mem[pair_q] <= 1'b1;
    end
    if (cmd_i.read) seen_rd_q <= seen_mem[pair_q];
  end

  // Last sequence memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) last_mem[pair_q] <= seq_q;
    if (cmd_i.read) last_rd_q <= last_mem[pair_q];
  end

  // Gap and saturating counter updates
  always_comb begin
    gap    = seen_rd_q ? (seq_q - last_rd_q - 1'b1) : '0;
    rc_new = (rc_q == CNT_MAX) ? rc_q : (rc_q + 1'b1);
    lsum   = {1'b0, lc_q} + (COUNT_BITS + 1)'(gap);
    lc_new = lsum[COUNT_BITS] ? CNT_MAX : lsum[COUNT_BITS-1:0];
    dsum   = {1'b0, rc_q} + {1'b0, lc_q};
    ntmp   = num_q + NUM_W'(lc_q);
    num_ge = (num_q >= den_q);
    sm_sum = (LOSS_W + 1)'(quo_q) + (LOSS_W + 1)'(sm_old_q);
  end

  // Channel state: write back bumped counters and smoothed loss
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        recv_q[i]   <= '0;
        lost_q[i]   <= '0;
        smooth_q[i] <= '0;
      end
    end else begin
      if (cmd_i.update) begin
        recv_q[ch_q] <= rc_new;
        lost_q[ch_q] <= lc_new;
      end
      if (cmd_i.smooth) smooth_q[ch_q] <= sm_sum[LOSS_W:1];
    end
  end

  // Ratio datapath: scale lost count, then divide one bit a step
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rc_q     <= recv_q[ch_q];
      lc_q     <= lost_q[ch_q];
      sm_old_q <= smooth_q[ch_q];
    end
    if (cmd_i.update) begin
      rc_q  <= rc_new;
      lc_q  <= lc_new;
      gap_q <= gap;
    end
    if (cmd_i.mul1) begin
      // lost * 24 first, lost * 25 * 1024 next
      num_q <= NUM_W'({lc_q, 4'b0}) + NUM_W'({lc_q, 3'b0});
      den_q <= {dsum, {DEN_SHIFT{1'b0}}};
    end
    if (cmd_i.mul2) begin
      num_q <= {ntmp[NUM_W-1-SCALE_SHIFT:0], {SCALE_SHIFT{1'b0}}};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (num_ge) num_q <= num_q - den_q;
      quo_q <= {quo_q[LOSS_W-2:0], num_ge};
      den_q <= den_q >> 1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.smooth) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smooth) begin
      lost_now_o       <= gap_q;
      received_total_o <= TOT_W'(rc_q);
      lost_total_o     <= TOT_W'(lc_q);
      loss_percent_o   <= sm_sum[LOSS_W:1];
      report_o         <= (rc_q[REPORT_W-1:0] == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Checks
  a_smooth_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.smooth |-> status_o.out_free)
    else $error("result loaded over a waiting result");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.smooth |-> (quo_q < LOSS_SCALE))
    else $error("loss ratio above full scale");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (den_q != '0))
    else $error("ratio divider with zero denominator");

endmodule

// File: bench/tb_sequence_gap_loss_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequence_gap_loss_monitor
// Drives frame requests into the loss monitor and checks every result against
// an in-bench tracker of per-pair sequence gaps and per-channel loss figures.
// Directed frames cover first frames, wrap, duplicates and extreme identifiers.
// Random traffic follows a small pool of sender pairs, mostly in order.
// ----------------------------------------------------------------------------
module tb_sequence_gap_loss_monitor import sglm_pkg::*; ();

  localparam int unsigned RANDOM_FRAMES = 1200;
  localparam int unsigned POOL_SIZE     = 8;
  localparam int          STALL_LIMIT   = 400000;  // covers the seen-table clear
  localparam int          TAIL_CYCLES   = 40;
  localparam logic [63:0] CNT_MAX       = {64{1'b1}} >> (64 - COUNT_BITS_DEF);

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [ID_W-1:0]   sys_id;
    logic [ID_W-1:0]   comp_id;
    logic [SEQ_W-1:0]  seq;
  } frame_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  lost_now;
    logic [TOT_W-1:0]  received_total;
    logic [TOT_W-1:0]  lost_total;
    logic [LOSS_W-1:0] loss_percent;
    logic              report;
  } loss_result_t;

  typedef enum logic [1:0] {
    SINK_OPEN, SINK_COIN, SINK_COMB, SINK_STARVE
  } sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  sglm_in_if  frame_if ();
  sglm_out_if result_if ();

  sequence_gap_loss_monitor u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_if),
    .result_o (result_if)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and expectations
  frame_t       frames_pending[$];
  loss_result_t results_due[$];
  int           mismatches   = 0;
  int           stall_cycles = 0;

  // Tracker state: sender pairs and channel statistics
  logic [SEQ_W-1:0]  pair_last_seq [1 << PAIR_W];
  bit                pair_known    [1 << PAIR_W];
  logic [63:0]       rx_count      [CHANNELS_DEF];
  logic [63:0]       loss_count    [CHANNELS_DEF];
  logic [LOSS_W-1:0] smooth_loss   [CHANNELS_DEF];

  // Generator pool of sender pairs
  logic [PAIR_W-1:0] pool_pair [POOL_SIZE];
  logic [CHAN_W-1:0] pool_chan [POOL_SIZE];
  logic [SEQ_W-1:0]  pool_last [POOL_SIZE];

  int unsigned burst_left;
  int unsigned pause_left;
  int unsigned sink_cycle;
  sink_mode_e  sink_mode;

  initial begin
    foreach (pair_known[i]) pair_known[i] = 1'b0;
    foreach (rx_count[i]) begin
      rx_count[i]    = '0;
      loss_count[i]  = '0;
      smooth_loss[i] = '0;
    end
  end

  task automatic queue_frame(input logic [CHAN_W-1:0] ch, input logic [ID_W-1:0] sys,
                             input logic [ID_W-1:0] comp, input logic [SEQ_W-1:0] sq);
    frames_pending.push_back('{channel: ch, sys_id: sys, comp_id: comp, seq: sq});
  endtask

  // Advance the tracker by one frame and queue the result it must produce
  task automatic account_frame(input frame_t f);
    int unsigned       ch;
    logic [PAIR_W-1:0] pair;
    logic [SEQ_W-1:0]  gap;
    logic [63:0]       rc;
    logic [63:0]       lc;
    logic [63:0]       quot;
    logic [LOSS_W:0]   sum;
    loss_result_t      r;
    ch   = f.channel % CHANNELS_DEF;
    pair = {f.sys_id, f.comp_id};
    gap  = '0;
    if (pair_known[pair]) begin
      gap = f.seq - pair_last_seq[pair] - 8'd1;
    end else begin
      pair_known[pair] = 1'b1;
    end
    pair_last_seq[pair] = f.seq;
    rc = rx_count[ch];
    if (rc < CNT_MAX) rc = rc + 64'd1;
    lc = loss_count[ch];
    if (CNT_MAX - lc < 64'(gap)) lc = CNT_MAX;
    else lc = lc + 64'(gap);
    rx_count[ch]   = rc;
    loss_count[ch] = lc;
    quot = (lc * 64'(LOSS_SCALE)) / (rc + lc);
    sum  = {1'b0, quot[LOSS_W-1:0]} + {1'b0, smooth_loss[ch]};
    smooth_loss[ch]  = sum[LOSS_W:1];
    r.lost_now       = gap;
    r.received_total = rc[TOT_W-1:0];
    r.lost_total     = lc[TOT_W-1:0];
    r.loss_percent   = sum[LOSS_W:1];
    r.report         = (rc[4:0] == 5'd0);
    results_due.push_back(r);
  endtask

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: bursts of requests separated by random pauses
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_if.valid   <= 1'b0;
      frame_if.channel <= '0;
      frame_if.sys_id  <= '0;
      frame_if.comp_id <= '0;
      frame_if.seq     <= '0;
      burst_left       <= 0;
      pause_left       <= 0;
    end else begin
      if (frame_if.valid && frame_if.ready) void'(frames_pending.pop_front());
      // hold an offered request until it is taken
      if (!frame_if.valid || frame_if.ready) begin
        if (pause_left != 0) begin
          frame_if.valid <= 1'b0;
          pause_left     <= pause_left - 1;
        end else if (frames_pending.size() == 0) begin
          frame_if.valid <= 1'b0;
        end else begin
          frame_if.valid   <= 1'b1;
          frame_if.channel <= frames_pending[0].channel;
          frame_if.sys_id  <= frames_pending[0].sys_id;
          frame_if.comp_id <= frames_pending[0].comp_id;
          frame_if.seq     <= frames_pending[0].seq;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 12);
            pause_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
          end
        end
      end
    end
  end

  // Receiver: ready pattern chosen at random whenever sink_cycle[6:0] is zero
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      sink_cycle      <= 0;
      sink_mode       <= SINK_OPEN;
    end else begin
      sink_cycle <= sink_cycle + 1;
      if (sink_cycle[6:0] == 7'd0) sink_mode <= sink_mode_e'($urandom_range(0, 3));
      case (sink_mode)
        SINK_OPEN:   result_if.ready <= 1'b1;
        SINK_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
        SINK_COMB:   result_if.ready <= (sink_cycle % 5) > 1;
        default:     result_if.ready <= (sink_cycle % 29) == 0;
      endcase
    end
  end

  // Monitor: check results first, then record accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, lost_now %0d received_total %0d",
                   $time, result_if.lost_now, result_if.received_total);
        end else begin
          compare_field("lost_now", 64'(results_due[0].lost_now),
                        64'(result_if.lost_now));
          compare_field("received_total", 64'(results_due[0].received_total),
                        64'(result_if.received_total));
          compare_field("lost_total", 64'(results_due[0].lost_total),
                        64'(result_if.lost_total));
          compare_field("loss_percent", 64'(results_due[0].loss_percent),
                        64'(result_if.loss_percent));
          compare_field("report", 64'(results_due[0].report), 64'(result_if.report));
          void'(results_due.pop_front());
        end
      end
      if (frame_if.valid && frame_if.ready) begin
        account_frame('{channel: frame_if.channel, sys_id: frame_if.sys_id,
                        comp_id: frame_if.comp_id, seq: frame_if.seq});
      end
      if ((result_if.valid && result_if.ready) || (frame_if.valid && frame_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned k;
    int unsigned pick;
    int unsigned step;
    bit          timed_out;
    rst_ni <= 1'b0;

    // Directed: first frames, in order, gaps, wrap, duplicates, extreme ids
    queue_frame(4'd0, 8'h00, 8'h00, 8'd0);
    queue_frame(4'd0, 8'h00, 8'h00, 8'd1);
    queue_frame(4'd0, 8'h00, 8'h00, 8'd5);
    queue_frame(4'd0, 8'h00, 8'h00, 8'd255);
    queue_frame(4'd0, 8'h00, 8'h00, 8'd0);     // wrap from 255 to 0
    queue_frame(4'd0, 8'h00, 8'h00, 8'd0);     // repeated number
    queue_frame(4'd15, 8'hFF, 8'hFF, 8'd255);
    queue_frame(4'd15, 8'hFF, 8'hFF, 8'd255);
    queue_frame(4'd15, 8'hFF, 8'hFF, 8'd254);  // stepping backwards
    queue_frame(4'd5, 8'hAA, 8'h55, 8'h80);
    queue_frame(4'd10, 8'hAA, 8'h55, 8'h81);   // same pair, other channel
    queue_frame(4'd5, 8'h55, 8'hAA, 8'h7F);
    queue_frame(4'd5, 8'h55, 8'hAA, 8'h7E);
    queue_frame(4'd5, 8'hAA, 8'h55, 8'h01);
    queue_frame(4'd10, 8'h00, 8'hFF, 8'h00);
    queue_frame(4'd10, 8'hFF, 8'h00, 8'hFF);
    queue_frame(4'd10, 8'h00, 8'hFF, 8'hFF);
    queue_frame(4'd10, 8'hFF, 8'h00, 8'h00);

    // Pool of senders: extreme pairs plus random ones
    for (k = 0; k < POOL_SIZE; k++) begin
      pool_pair[k] = PAIR_W'($urandom_range(0, 16'hFFFF));
      pool_chan[k] = CHAN_W'($urandom_range(0, 15));
      pool_last[k] = SEQ_W'($urandom_range(0, 255));
    end
    pool_pair[0] = 16'h0000;
    pool_pair[1] = 16'hFFFF;
    pool_pair[2] = 16'h00FF;
    pool_pair[3] = 16'hFF00;

    // Random: mostly in-order streams with occasional loss, noise and new senders
    for (k = 0; k < RANDOM_FRAMES; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        queue_frame(CHAN_W'($urandom_range(0, 15)), ID_W'($urandom_range(0, 255)),
                    ID_W'($urandom_range(0, 255)), SEQ_W'($urandom_range(0, 255)));
      end else begin
        step = $urandom_range(0, POOL_SIZE - 1);
        if (pick < 9) begin
          // replace a sender with a fresh one
          pool_pair[step] = PAIR_W'($urandom_range(0, 16'hFFFF));
          pool_chan[step] = CHAN_W'($urandom_range(0, 15));
          pool_last[step] = SEQ_W'($urandom_range(0, 255));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 65)      pool_last[step] = pool_last[step] + 8'd1;
          else if (pick < 80) pool_last[step] = pool_last[step] + 8'($urandom_range(2, 6));
          else if (pick < 88) pool_last[step] = SEQ_W'($urandom_range(0, 255));
          else if (pick < 94) pool_last[step] = pool_last[step];
          else                pool_last[step] = pool_last[step] + 8'($urandom_range(200, 255));
        end
        queue_frame(($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : pool_chan[step],
                    pool_pair[step][15:8], pool_pair[step][7:0], pool_last[step]);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain, then let the pipeline settle
    while ((frames_pending.size() != 0 || results_due.size() != 0) &&
           stall_cycles < STALL_LIMIT)
      @(negedge clk_i);
    timed_out = (stall_cycles >= STALL_LIMIT);
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk_i);

    if (!timed_out && mismatches == 0 && results_due.size() == 0)
      $display("tb_sequence_gap_loss_monitor OK");
    else
      $display("tb_sequence_gap_loss_monitor NOT OK");
    $finish;
  end

endmodule
